// ----- rtl/hsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types, constants and helpers for the hall sensor phase feedback unit.
// ----------------------------------------------------------------------------
package hsp_pkg;

	localparam int ANGLE_BITS_DEF   = 16;
	localparam int EXPIRY_TICKS_DEF = 600;
	localparam int VOLTAGE_BITS_DEF = 12;
	localparam int EDGE_STATES      = 12;
	localparam int ANGLE_MAX        = 32;
	localparam int VOLT_MAX         = 16;
	localparam logic [VOLT_MAX-1:0] STALL_RESET = 16'd1024;

	typedef enum logic [4:0] {
		F_A1 = 5'd0,  F_B1 = 5'd1,  F_C1 = 5'd2,  F_A0 = 5'd3,  F_B0 = 5'd4,
		F_C0 = 5'd5,  R_A1 = 5'd6,  R_B1 = 5'd7,  R_C1 = 5'd8,  R_A0 = 5'd9,
		R_B0 = 5'd10, R_C0 = 5'd11, P_A1 = 5'd12, P_B1 = 5'd13, P_C1 = 5'd14,
		P_A0 = 5'd15, P_B0 = 5'd16, P_C0 = 5'd17, DEC_START = 5'd18
	} hall_code_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_EDGE  = 2'd1,
		OP_TICK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// spare mode is taken and ignored
	typedef enum logic [1:0] {
		MODE_EDGE    = 2'd0,
		MODE_TICK    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_SPARE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_PROP  = 3'd0,
		REG_IGAIN = 3'd1,
		REG_DERIV = 3'd2,
		REG_TGAIN = 3'd3,
		REG_STALL = 3'd4,
		REG_SPEED = 3'd5,
		REG_HOLD  = 3'd6
	} reg_idx_t;

	localparam logic [1:0] PIN_NONE = 2'd3;

	// next code per [code][{pin, level}], columns A0 A1 B0 B1 C0 C1
	localparam hall_code_t NEXT_TAB [19][6] = '{
		'{R_A0, F_A1, R_B0, F_B1, F_C0, R_C1},
		'{F_A0, R_A1, R_B0, F_B1, R_C0, F_C1},
		'{R_A0, F_A1, F_B0, R_B1, R_C0, F_C1},
		'{F_A0, R_A1, R_B0, F_B1, R_C0, F_C1},
		'{R_A0, F_A1, F_B0, R_B1, R_C0, F_C1},
		'{R_A0, F_A1, R_B0, F_B1, F_C0, R_C1},
		'{F_A0, R_A1, R_B0, F_B1, F_C0, R_C1},
		'{F_A0, R_A1, F_B0, R_B1, R_C0, F_C1},
		'{R_A0, F_A1, F_B0, R_B1, F_C0, R_C1},
		'{R_A0, F_A1, F_B0, R_B1, F_C0, R_C1},
		'{F_A0, R_A1, R_B0, F_B1, F_C0, R_C1},
		'{F_A0, R_A1, F_B0, R_B1, R_C0, F_C1},
		'{P_A0, P_A0, R_B0, F_B1, F_C0, R_C1},
		'{F_A0, R_A1, P_B0, P_B0, R_C0, F_C1},
		'{R_A0, F_A1, F_B0, R_B1, P_C0, P_C0},
		'{P_A0, P_A0, R_B0, F_B1, R_C0, F_C1},
		'{R_A0, F_A1, P_B0, P_B0, R_C0, F_C1},
		'{R_A0, F_A1, R_B0, F_B1, P_C0, P_C0},
		'{P_A0, P_A1, P_B0, P_B1, P_C0, P_C1}
	};

	typedef struct packed {
		op_t               op;
		hall_code_t        code;
		logic [ANGLE_MAX-1:0] angle;
		logic signed [31:0] vel;
	} q_entry_t;

	typedef struct packed {
		logic signed [31:0] prop;
		logic signed [31:0] igain;
		logic signed [31:0] deriv;
		logic signed [31:0] tgain;
		logic signed [31:0] speed;
		logic [VOLT_MAX-1:0] stall;
		logic [VOLT_MAX-1:0] hold;
	} cfg_t;

	typedef struct packed {
		logic               drive_valid;
		logic [VOLT_MAX-1:0] drive_voltage;
		logic signed [31:0] lead;
		logic signed [31:0] vel;
		logic               limited;
		logic               stalled;
		logic               in_sync;
		hall_code_t         edge_state;
	} res_t;

	function automatic hall_code_t next_code(hall_code_t c, logic [1:0] pin, logic lvl);
		logic [2:0] col;
		col = {pin, lvl};
		if (c <= DEC_START && col <= 3'd5) begin
			return NEXT_TAB[c][col];
		end
		return c;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// ----- rtl/hsp_front.sv -----
// ----------------------------------------------------------------------------
// hsp_front
// Takes input requests, runs the hall edge decoder and classifies each request.
// ----------------------------------------------------------------------------
module hsp_front #(
	parameter int ANGLE_BITS = hsp_pkg::ANGLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [1:0]            hall_pin,
	input  logic                  pin_level,
	input  logic [ANGLE_BITS-1:0] rotor_angle,
	input  logic signed [31:0]    velocity_in,
	input  logic                  q_full,
	output logic                  q_push,
	output hsp_pkg::q_entry_t     q_data
);
	import hsp_pkg::*;

	hall_code_t dec_q;
	hall_code_t dec_nx;
	logic       is_edge;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign is_edge  = (mode == MODE_EDGE) && (hall_pin != PIN_NONE);
	assign dec_nx   = is_edge ? next_code(dec_q, hall_pin, pin_level) : dec_q;

	always_comb begin
		q_data       = '0;
		q_data.code  = dec_nx;
		q_data.angle = ANGLE_MAX'(rotor_angle);
		q_data.vel   = velocity_in;
		if (is_edge) begin
			q_data.op = (dec_nx < hall_code_t'(EDGE_STATES)) ? OP_EDGE : OP_NONE;
		end else if (mode == MODE_TICK) begin
			q_data.op = OP_TICK;
		end else if (mode == MODE_RESTART) begin
			q_data.op = OP_CLEAR;
		end else begin
			q_data.op = OP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q <= DEC_START;
		end else if (q_push) begin
			dec_q <= dec_nx;
		end
	end

endmodule

// ----- rtl/hsp_queue.sv -----
// ----------------------------------------------------------------------------
// hsp_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module hsp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hsp_pkg::q_entry_t wr_data,
	output logic              full,
	input  logic              pop,
	output hsp_pkg::q_entry_t rd_data,
	output logic              empty
);
	import hsp_pkg::*;

	q_entry_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- rtl/hsp_back.sv -----
// ----------------------------------------------------------------------------
// hsp_back
// Executes queued requests: angle table, feedback loop, tick drive and stall.
// ----------------------------------------------------------------------------
module hsp_back #(
	parameter int ANGLE_BITS   = hsp_pkg::ANGLE_BITS_DEF,
	parameter int EXPIRY_TICKS = hsp_pkg::EXPIRY_TICKS_DEF,
	parameter int VOLTAGE_BITS = hsp_pkg::VOLTAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hsp_pkg::q_entry_t q_data,
	input  logic              q_empty,
	output logic              q_pop,
	input  hsp_pkg::cfg_t     cfg,
	output logic              out_valid,
	input  logic              out_ready,
	output hsp_pkg::res_t     res
);
	import hsp_pkg::*;

	localparam int EXP_W = $clog2(EXPIRY_TICKS + 1);
	localparam logic signed [63:0] QUARTER = 64'sd1 <<< (ANGLE_BITS - 2);

	typedef enum logic [10:0] {
		B_IDLE = 11'b00000000001,
		B_EXEC = 11'b00000000010,
		B_INT  = 11'b00000000100,
		B_TRQ  = 11'b00000001000,
		B_DER  = 11'b00000010000,
		B_PRO  = 11'b00000100000,
		B_IGN  = 11'b00001000000,
		B_LEAD = 11'b00010000000,
		B_TMUL = 11'b00100000000,
		B_TVEL = 11'b01000000000,
		B_FIN  = 11'b10000000000
	} bstate_t;

	bstate_t st_q;
	q_entry_t cur_q;
	logic [ANGLE_BITS-1:0] tab_q [EDGE_STATES];
	logic [EDGE_STATES-1:0] seen_q;
	logic sync_q;
	logic signed [31:0] pe_q, ei_q, lead_q, torque_q;
	logic [EXP_W-1:0] exp_q;
	logic signed [ANGLE_BITS-1:0] chg_q;
	logic signed [33:0] over_q;
	logic signed [63:0] prod_q, acc_q;
	logic r_valid_q, r_lim_q, r_stall_q;
	logic [VOLTAGE_BITS-1:0] r_volt_q;
	logic signed [31:0] r_lead_q, r_vel_q;
	res_t res_q;
	logic out_valid_q;

	logic [3:0] idx;
	logic [ANGLE_BITS-1:0] angle_c;
	logic signed [ANGLE_BITS-1:0] chg_c;
	logic signed [31:0] pe_c;
	logic signed [63:0] prod_sh, lead_sum, lead_cl, trq_abs;
	logic signed [33:0] mul_a;
	logic signed [31:0] mul_b;
	logic [32:0] v_c;
	logic signed [33:0] over_c;
	logic signed [31:0] vel_c;
	logic out_free, fin_go, tick_live, sync_nx;

	assign idx      = cur_q.code[3:0];
	assign angle_c  = cur_q.angle[ANGLE_BITS-1:0];
	// modular difference is the change wrapped into half a turn either way
	assign chg_c    = $signed(angle_c - tab_q[idx]);
	assign pe_c     = sat32(64'(pe_q) + 64'(chg_c));
	assign prod_sh  = prod_q >>> 16;
	assign trq_abs  = prod_sh[63] ? -prod_sh : prod_sh;
	assign lead_sum = acc_q + prod_sh;
	assign v_c      = 33'($unsigned(torque_q)) + 33'(cfg.hold[VOLTAGE_BITS-1:0]);
	assign over_c   = $signed({1'b0, v_c}) - $signed(34'(cfg.stall));
	assign vel_c    = sat32(64'(cur_q.vel) - prod_sh);

	assign out_free  = !out_valid_q || out_ready;
	assign fin_go    = (st_q == B_FIN) && out_free;
	assign tick_live = (cur_q.op == OP_TICK) && (exp_q != '0);
	assign sync_nx   = r_stall_q ? 1'b0 : sync_q;
	assign q_pop     = (st_q == B_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		if (lead_sum > QUARTER) begin
			lead_cl = QUARTER;
		end else if (lead_sum < -QUARTER) begin
			lead_cl = -QUARTER;
		end else begin
			lead_cl = lead_sum;
		end
	end

	// one shared multiplier, operands picked by the sequencer step
	always_comb begin
		case (st_q)
			B_TRQ: begin
				mul_a = 34'(ei_q);
				mul_b = cfg.tgain;
			end
			B_DER: begin
				mul_a = 34'(chg_q);
				mul_b = cfg.deriv;
			end
			B_PRO: begin
				mul_a = 34'(pe_q);
				mul_b = cfg.prop;
			end
			B_IGN: begin
				mul_a = 34'(ei_q);
				mul_b = cfg.igain;
			end
			default: begin
				mul_a = over_q;
				mul_b = cfg.speed;
			end
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a * mul_b);
		if (q_pop) begin
			cur_q     <= q_data;
			r_valid_q <= 1'b0;
			r_volt_q  <= '0;
			r_lead_q  <= '0;
			r_vel_q   <= '0;
			r_lim_q   <= 1'b0;
			r_stall_q <= 1'b0;
		end
		case (st_q)
			B_EXEC: begin
				if (cur_q.op == OP_EDGE) begin
					if (sync_q) begin
						chg_q <= chg_c;
						if (chg_c != '0) begin
							tab_q[idx] <= angle_c;
						end
					end else if (!seen_q[idx]) begin
						tab_q[idx] <= angle_c;
					end
				end else if (cur_q.op == OP_TICK) begin
					r_vel_q <= cur_q.vel;
					over_q  <= over_c;
					if (exp_q != '0) begin
						r_valid_q <= 1'b1;
						r_lead_q  <= lead_q;
						if (over_c > 34'sd0) begin
							r_volt_q <= cfg.stall[VOLTAGE_BITS-1:0];
							r_lim_q  <= 1'b1;
						end else begin
							r_volt_q <= v_c[VOLTAGE_BITS-1:0];
						end
					end
				end
			end
			B_PRO: acc_q <= prod_sh;
			B_IGN: acc_q <= lead_sum;
			B_TVEL: begin
				if (vel_c <= 32'sd0) begin
					r_vel_q   <= '0;
					r_valid_q <= 1'b0;
					r_stall_q <= 1'b1;
				end else begin
					r_vel_q <= vel_c;
				end
			end
			default: ;
		endcase
		if (fin_go) begin
			res_q.drive_valid   <= r_valid_q;
			res_q.drive_voltage <= VOLT_MAX'(r_volt_q);
			res_q.lead          <= r_lead_q;
			res_q.vel           <= r_vel_q;
			res_q.limited       <= r_lim_q;
			res_q.stalled       <= r_stall_q;
			res_q.in_sync       <= sync_nx;
			res_q.edge_state    <= cur_q.code;
		end
	end

	// control and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			seen_q      <= '0;
			sync_q      <= 1'b0;
			pe_q        <= '0;
			ei_q        <= '0;
			lead_q      <= '0;
			torque_q    <= '0;
			exp_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				B_IDLE: begin
					if (q_pop) begin
						st_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					unique case (cur_q.op)
						OP_EDGE: begin
							if (sync_q) begin
								exp_q <= EXP_W'(EXPIRY_TICKS);
								if (chg_c != '0) begin
									pe_q <= pe_c;
									st_q <= B_INT;
								end else begin
									st_q <= B_FIN;
								end
							end else begin
								st_q <= B_FIN;
								if (!seen_q[idx]) begin
									seen_q[idx] <= 1'b1;
									if (&(seen_q | (EDGE_STATES'(1) << idx))) begin
										sync_q <= 1'b1;
									end
								end
							end
						end
						OP_TICK: begin
							if (exp_q != '0 && over_c > 34'sd0) begin
								st_q <= B_TMUL;
							end else begin
								st_q <= B_FIN;
							end
						end
						OP_CLEAR: begin
							sync_q <= 1'b0;
							seen_q <= '0;
							st_q   <= B_FIN;
						end
						OP_NONE: st_q <= B_FIN;
					endcase
				end
				B_INT: begin
					ei_q <= sat32(64'(ei_q) + 64'(pe_q));
					st_q <= B_TRQ;
				end
				B_TRQ: st_q <= B_DER;
				B_DER: begin
					torque_q <= sat32(trq_abs);
					st_q     <= B_PRO;
				end
				B_PRO: st_q <= B_IGN;
				B_IGN: st_q <= B_LEAD;
				B_LEAD: begin
					lead_q <= sat32(lead_cl - 64'(pe_q));
					st_q   <= B_FIN;
				end
				B_TMUL: st_q <= B_TVEL;
				B_TVEL: st_q <= B_FIN;
				B_FIN: begin
					if (out_free) begin
						sync_q <= sync_nx;
						if (tick_live) begin
							exp_q <= r_stall_q ? '0 : exp_q - EXP_W'(1);
						end
						st_q <= B_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/hall_sensor_phase_feedback_unit.sv -----
// ----------------------------------------------------------------------------
// hall_sensor_phase_feedback_unit
// Hall edge decoder with angle capture, phase feedback loop and tick drive.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | input     | in_valid / in_ready   | mode hall_pin pin_level ...
//  out      | output    | out_valid / out_ready | drive_valid ... edge_state
//  cfg      | input     | cfg_valid / cfg_ready | cfg_index cfg_data
//
//  requests enter each cycle while the two-entry queue has room
//  back part per request: EXEC, FIN; a live tick over stall adds TMUL, TVEL;
//  an in-sync edge with change adds INT TRQ DER PRO IGN LEAD; one shared
//  34x32 multiplier, one step a cycle but FIN waits until output is taken
//  reset sets decoder, seen bits, loop state, queue, cfg, out_valid; no clear pass
// ----------------------------------------------------------------------------
module hall_sensor_phase_feedback_unit #(
	parameter int ANGLE_BITS   = hsp_pkg::ANGLE_BITS_DEF,
	parameter int EXPIRY_TICKS = hsp_pkg::EXPIRY_TICKS_DEF,
	parameter int VOLTAGE_BITS = hsp_pkg::VOLTAGE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              mode,
	input  logic [1:0]              hall_pin,
	input  logic                    pin_level,
	input  logic [ANGLE_BITS-1:0]   rotor_angle,
	input  logic signed [31:0]      velocity_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    drive_valid,
	output logic [VOLTAGE_BITS-1:0] drive_voltage,
	output logic signed [31:0]      lead_angle_delta,
	output logic signed [31:0]      velocity_out,
	output logic                    voltage_limited,
	output logic                    stalled,
	output logic                    in_sync,
	output logic [4:0]              edge_state,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data
);
	import hsp_pkg::*;

	cfg_t     cfg_q;
	q_entry_t f_data, b_data;
	logic     q_push, q_pop, q_full, q_empty;
	res_t     res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{prop: '0, igain: '0, deriv: '0, tgain: '0, speed: '0,
				stall: STALL_RESET, hold: '0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PROP:  cfg_q.prop  <= cfg_data;
				REG_IGAIN: cfg_q.igain <= cfg_data;
				REG_DERIV: cfg_q.deriv <= cfg_data;
				REG_TGAIN: cfg_q.tgain <= cfg_data;
				REG_STALL: cfg_q.stall <= VOLT_MAX'(cfg_data[VOLTAGE_BITS-1:0]);
				REG_SPEED: cfg_q.speed <= cfg_data;
				REG_HOLD:  cfg_q.hold  <= VOLT_MAX'(cfg_data[VOLTAGE_BITS-1:0]);
				default: ;
			endcase
		end
	end

	hsp_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .hall_pin(hall_pin), .pin_level(pin_level),
		.rotor_angle(rotor_angle), .velocity_in(velocity_in),
		.q_full(q_full), .q_push(q_push), .q_data(f_data)
	);

	hsp_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wr_data(f_data), .full(q_full),
		.pop(q_pop), .rd_data(b_data), .empty(q_empty)
	);

	hsp_back #(
		.ANGLE_BITS(ANGLE_BITS), .EXPIRY_TICKS(EXPIRY_TICKS), .VOLTAGE_BITS(VOLTAGE_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_data(b_data), .q_empty(q_empty), .q_pop(q_pop),
		.cfg(cfg_q), .out_valid(out_valid), .out_ready(out_ready), .res(res)
	);

	assign drive_valid      = res.drive_valid;
	assign drive_voltage    = res.drive_voltage[VOLTAGE_BITS-1:0];
	assign lead_angle_delta = res.lead;
	assign velocity_out     = res.vel;
	assign voltage_limited  = res.limited;
	assign stalled          = res.stalled;
	assign in_sync          = res.in_sync;
	assign edge_state       = res.edge_state;

	a_stall_drops_sync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stalled |-> !in_sync && !drive_valid && velocity_out == 32'sd0)
		else $error("stall result with live drive or sync");

	a_limit_at_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && voltage_limited |->
			drive_voltage == cfg_q.stall[VOLTAGE_BITS-1:0])
		else $error("limited voltage differs from stall voltage");

	a_drive_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_valid |-> !stalled)
		else $error("drive valid together with stall");

endmodule
